// ----- design/rclf_pkg.sv -----
// Shared types and constants for the remote command latch framer.
package rclf_pkg;

  typedef struct packed {
    logic       operation;
    logic [5:0] message_length;
    logic [7:0] key_byte;
    logic [7:0] command_byte;
  } rclf_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } rclf_result_t;

  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic CFG_AUTH_KEY     = 1'b0;
  localparam logic CFG_FRAME_PERIOD = 1'b1;

  localparam logic [7:0]  AUTH_KEY_RESET     = 8'd100;
  localparam logic [15:0] FRAME_PERIOD_RESET = 16'd50;
  localparam logic [7:0]  PREV_CMD_RESET     = 8'd255;
  localparam logic [5:0]  MIN_MSG_LENGTH     = 6'd2;

  localparam logic [7:0] HDR0 = 8'd68;
  localparam logic [7:0] HDR1 = 8'd84;
  localparam logic [7:0] HDR2 = 8'd89;

  localparam logic [7:0] CMD_RELEASE = 8'd0;
  localparam logic [7:0] CMD_AUTO    = 8'd72;
  localparam logic [7:0] CMD_MACHINE = 8'd80;
  localparam logic [7:0] CMD_TANK    = 8'd70;
  localparam logic [7:0] CMD_BIT4    = 8'd76;
  localparam logic [7:0] CMD_BIT3    = 8'd75;
  localparam logic [7:0] CMD_BIT2    = 8'd79;
  localparam logic [7:0] CMD_BIT1    = 8'd71;
  localparam logic [7:0] CMD_BIT7    = 8'd78;
  localparam logic [7:0] CMD_BIT8    = 8'd74;
  localparam logic [7:0] CMD_BIT9    = 8'd69;
  localparam logic [7:0] CMD_BIT10   = 8'd73;
  localparam logic [7:0] CMD_BIT15   = 8'd77;

  localparam logic [2:0] LAST_BYTE_IDX = 3'd4;

endpackage

// ----- design/remote_command_latch_framer_core.sv -----
// Remote command latch framer: command decoding, action word and status frame output.
//
// The block takes one input transaction per cycle on the item channel: either a
// received remote message or a one-millisecond tick. A message whose length is at
// least two, whose key byte equals auth_key and whose command differs from the
// last accepted command updates the action word; command 0 is a release that
// rebuilds the status bits and re-arms the block, any other command acts only
// while armed and then disarms it. Messages never produce output. A tick that
// brings the tick counter to at least frame_period snapshots the action word and
// produces a five-byte frame (68, 84, 89, low byte, high byte) as five result
// transactions, one per cycle while res_ready is high, with last_byte set on the
// fifth. An item is registered on acceptance and its state update and frame
// decision are made from that input register, so items can be accepted every
// cycle unless a stall holds it. Frames wait in a two-entry queue in front of the
// byte sequencer; the sequencer sends one byte per cycle while res_ready is high,
// and a frame-producing tick stalls in the input register only while both queue
// entries are taken. Configuration writes on cfg_write take effect at the same
// clock edge and are expected only while the block is idle.
module remote_command_latch_framer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rclf_pkg::rclf_item_t item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rclf_pkg::rclf_result_t res,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);
  import rclf_pkg::*;

  // Configuration registers.
  logic [7:0]  auth_key;
  logic [15:0] frame_period;

  // Input register.
  logic       item_held;
  rclf_item_t item_q;

  // Block state.
  logic [15:0] action_word, action_word_next;
  logic        auto_on, auto_on_next;
  logic        machine_on, machine_on_next;
  logic        tank_on, tank_on_next;
  logic        held_lock, held_lock_next;
  logic [7:0]  previous_command, previous_command_next;
  logic [15:0] tick_count, tick_count_next;

  // Frame queue and byte sequencer.
  logic [15:0] frame_word [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  frame_count;
  logic [2:0]  byte_idx;

  logic [15:0] tick_inc;
  logic        frame_hit;
  logic        fifo_full;
  logic        fire;
  logic        push;
  logic        load_out;
  logic        pop;
  logic [7:0]  byte_sel;
  logic        msg_ok;

  assign fifo_full  = frame_count == 2'd2;
  assign tick_inc   = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign frame_hit  = (item_q.operation == OP_TICK) && (tick_inc >= frame_period);
  assign fire       = item_held && !(frame_hit && fifo_full);
  assign item_ready = !item_held || fire;
  assign push       = fire && frame_hit;

  assign load_out = (frame_count != 2'd0) && (!res_valid || res_ready);
  assign pop      = load_out && (byte_idx == LAST_BYTE_IDX);

  assign msg_ok = (item_q.message_length >= MIN_MSG_LENGTH)
               && (item_q.key_byte == auth_key)
               && (item_q.command_byte != previous_command);

  // Next state for the registered item.
  always_comb begin
    action_word_next      = action_word;
    auto_on_next          = auto_on;
    machine_on_next       = machine_on;
    tank_on_next          = tank_on;
    held_lock_next        = held_lock;
    previous_command_next = previous_command;
    tick_count_next       = tick_count;
    if (item_q.operation == OP_TICK) begin
      tick_count_next = frame_hit ? 16'd0 : tick_inc;
    end else if (msg_ok) begin
      previous_command_next = item_q.command_byte;
      if (item_q.command_byte == CMD_RELEASE) begin
        // Release rebuilds the word from the latched status bits and re-arms.
        action_word_next     = '0;
        action_word_next[0]  = auto_on;
        action_word_next[13] = machine_on;
        action_word_next[5]  = tank_on;
        held_lock_next       = 1'b0;
      end else if (!held_lock) begin
        held_lock_next = 1'b1;
        case (item_q.command_byte)
          CMD_AUTO: begin
            auto_on_next        = !auto_on;
            action_word_next[0] = !auto_on;
          end
          CMD_MACHINE: begin
            machine_on_next      = !machine_on;
            action_word_next[13] = !machine_on;
          end
          CMD_TANK: begin
            // The tank status bit itself only follows on release.
            tank_on_next        = !tank_on;
            action_word_next[6] = 1'b1;
          end
          CMD_BIT4:  action_word_next[4]  = 1'b1;
          CMD_BIT3:  action_word_next[3]  = 1'b1;
          CMD_BIT2:  action_word_next[2]  = 1'b1;
          CMD_BIT1:  action_word_next[1]  = 1'b1;
          CMD_BIT7:  action_word_next[7]  = 1'b1;
          CMD_BIT8:  action_word_next[8]  = 1'b1;
          CMD_BIT9:  action_word_next[9]  = 1'b1;
          CMD_BIT10: action_word_next[10] = 1'b1;
          CMD_BIT15: action_word_next[15] = 1'b1;
          default: begin
          end
        endcase
      end
    end
  end

  // Byte selection for the head frame of the queue.
  always_comb begin
    case (byte_idx)
      3'd0:    byte_sel = HDR0;
      3'd1:    byte_sel = HDR1;
      3'd2:    byte_sel = HDR2;
      3'd3:    byte_sel = frame_word[rd_ptr][7:0];
      3'd4:    byte_sel = frame_word[rd_ptr][15:8];
      default: byte_sel = HDR0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_key     <= AUTH_KEY_RESET;
      frame_period <= FRAME_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_AUTH_KEY:     auth_key     <= cfg_data[7:0];
        CFG_FRAME_PERIOD: frame_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      action_word      <= '0;
      auto_on          <= 1'b0;
      machine_on       <= 1'b0;
      tank_on          <= 1'b0;
      held_lock        <= 1'b0;
      previous_command <= PREV_CMD_RESET;
      tick_count       <= '0;
    end else if (fire) begin
      action_word      <= action_word_next;
      auto_on          <= auto_on_next;
      machine_on       <= machine_on_next;
      tank_on          <= tank_on_next;
      held_lock        <= held_lock_next;
      previous_command <= previous_command_next;
      tick_count       <= tick_count_next;
    end
  end

  // The frame carries the action word as it stands when the tick is processed.
  always_ff @(posedge clk) begin
    if (push) begin
      frame_word[wr_ptr] <= action_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= 1'b0;
      rd_ptr      <= 1'b0;
      frame_count <= '0;
      byte_idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   frame_count <= frame_count + 2'd1;
        2'b01:   frame_count <= frame_count - 2'd1;
        default: frame_count <= frame_count;
      endcase
      if (load_out) begin
        byte_idx <= pop ? 3'd0 : byte_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.out_byte  <= byte_sel;
      res.last_byte <= byte_idx == LAST_BYTE_IDX;
    end
  end

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    frame_count <= 2'd2)
    else $error("frame queue count out of range");

  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    byte_idx <= LAST_BYTE_IDX)
    else $error("byte index out of range");

  a_idx_idle : assert property (@(posedge clk) disable iff (rst)
    frame_count == 2'd0 |-> byte_idx == 3'd0)
    else $error("byte sequencer mid-frame with empty queue");

  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> item_held && frame_hit && fifo_full)
    else $error("input stalled without a full frame queue");

  a_push_room : assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("frame pushed into full queue");

endmodule
